### src/sfpbd_pkg.sv
`default_nettype none

package sfpbd_pkg;

   localparam int WordWidth     = 64;
   localparam int CsrIndexWidth = 2;
   localparam int WarmupSteps   = 20;
   localparam int MaxTries      = 1024;
   localparam int CountWidth    = $clog2(MaxTries);

   localparam logic [WordWidth-1:0] ResetSeedConstant = 64'h0000_0000_f1ea_5eed;
   localparam logic [WordWidth-1:0] ResetOutputMax    = {WordWidth{1'b1}};

   // Operation codes of the func field. The fourth code is ignored.
   localparam logic [1:0] FuncSeed    = 2'd0;
   localparam logic [1:0] FuncRaw     = 2'd1;
   localparam logic [1:0] FuncBounded = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrSeedConstant = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrOutputMax    = 2'd1;

   typedef struct packed {
      logic [1:0]           func;
      logic [WordWidth-1:0] seed_value;
      logic [WordWidth-1:0] bound;
   } sfpbd_req_type;

   typedef struct packed {
      logic [WordWidth-1:0] value;
      logic                 error;
   } sfpbd_rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEED_LOAD,
      ST_WARM,
      ST_RAW_STEP,
      ST_BND_CHECK,
      ST_CUT_DIV,
      ST_DRAW,
      ST_CHECK,
      ST_RED_DIV
   } sfpbd_state_type;

   typedef enum logic [1:0] {
      RSP_RAW,
      RSP_REMAINDER,
      RSP_ERROR
   } sfpbd_rsp_src_type;

   typedef enum logic {
      DIV_OUTPUT_MAX,
      DIV_DRAW
   } sfpbd_div_src_type;

   typedef struct packed {
      logic              capture;
      logic              load;
      logic              zero_seed;
      logic              step;
      logic              div_start;
      sfpbd_div_src_type div_src;
      logic              cutoff_load;
      logic              rsp_load;
      sfpbd_rsp_src_type rsp_src;
   } sfpbd_cmd_type;

   typedef struct packed {
      logic bound_zero;
      logic div_done;
      logic draw_ok;
   } sfpbd_status_type;

endpackage

`default_nettype wire

### src/sfpbd_div.sv
`default_nettype none

module sfpbd_div
   import sfpbd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WordWidth-1:0] dividend,
   input  wire logic [WordWidth-1:0] divisor,
   output logic                      done,
   output logic [WordWidth-1:0]      remainder
);

   localparam int IterWidth = $clog2(WordWidth);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [IterWidth-1:0] cnt_ff, cnt_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] dvd_ff, dvd_in;
   logic [WordWidth:0]   partial;
   logic [WordWidth:0]   diff;

   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   // The partial remainder stays below twice the divisor, so one subtract suffices.
   assign partial = {rem_ff, dvd_ff[WordWidth-1]};
   assign diff    = partial - {1'b0, divisor};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvd_in = dividend;
      end else if (run_ff) begin
         rem_in = (partial >= {1'b0, divisor}) ? diff[WordWidth-1:0]
                                               : partial[WordWidth-1:0];
         dvd_in = {dvd_ff[WordWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {IterWidth{1'b1}}) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff && !done_ff)
      else $error("divider started while still at work");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff) && !run_ff)
      else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

### src/sfpbd_dp.sv
`default_nettype none

module sfpbd_dp
   import sfpbd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sfpbd_cmd_type            cmd,
   output sfpbd_status_type              status,
   input  wire sfpbd_req_type            req_data,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [WordWidth-1:0]     csr_data,
   output sfpbd_rsp_type                 rsp_data
);

   localparam int RotB = 7;
   localparam int RotC = 13;
   localparam int RotD = 37;

   logic [WordWidth-1:0] seed_constant_ff, seed_constant_in;
   logic [WordWidth-1:0] output_max_ff, output_max_in;
   logic [WordWidth-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [WordWidth-1:0] seed_ff, seed_in;
   logic [WordWidth-1:0] bound_ff, bound_in;
   logic [WordWidth-1:0] cutoff_ff, cutoff_in;
   logic [WordWidth-1:0] draw_ff, draw_in;
   sfpbd_rsp_type        rsp_ff, rsp_in;

   logic [WordWidth-1:0] e_val, a_next, b_next, c_next, d_next, raw_val;
   logic [WordWidth-1:0] load_word;
   logic [WordWidth-1:0] div_dividend, div_rem, t_val;
   logic                 div_done;

   // One generator step.
   assign e_val   = a_ff - ((b_ff << RotB) | (b_ff >> (WordWidth - RotB)));
   assign a_next  = b_ff ^ ((c_ff << RotC) | (c_ff >> (WordWidth - RotC)));
   assign b_next  = c_ff + ((d_ff << RotD) | (d_ff >> (WordWidth - RotD)));
   assign c_next  = d_ff + e_val;
   assign d_next  = e_val + a_next;
   assign raw_val = d_next & output_max_ff;

   assign load_word    = cmd.zero_seed ? '0 : seed_ff;
   assign div_dividend = (cmd.div_src == DIV_DRAW) ? draw_ff : output_max_ff;
   assign t_val        = div_rem + 1'b1;

   sfpbd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      seed_constant_in = seed_constant_ff;
      output_max_in    = output_max_ff;
      if (csr_write) begin
         case (csr_index)
            CsrSeedConstant: seed_constant_in = csr_data;
            CsrOutputMax:    output_max_in    = csr_data;
            default: ;
         endcase
      end

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.load) begin
         a_in = seed_constant_ff;
         b_in = load_word;
         c_in = load_word;
         d_in = load_word;
      end else if (cmd.step) begin
         a_in = a_next;
         b_in = b_next;
         c_in = c_next;
         d_in = d_next;
      end

      seed_in  = cmd.capture ? req_data.seed_value : seed_ff;
      bound_in = cmd.capture ? req_data.bound : bound_ff;
      draw_in  = cmd.step ? raw_val : draw_ff;

      cutoff_in = cutoff_ff;
      if (cmd.cutoff_load) begin
         cutoff_in = (t_val == bound_ff) ? output_max_ff : output_max_ff - t_val;
      end

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         case (cmd.rsp_src)
            RSP_RAW:       rsp_in = '{value: raw_val, error: 1'b0};
            RSP_REMAINDER: rsp_in = '{value: div_rem, error: 1'b0};
            RSP_ERROR:     rsp_in = '{value: '0, error: 1'b1};
            default:       rsp_in = '{value: '0, error: 1'b0};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_constant_ff <= ResetSeedConstant;
         output_max_ff    <= ResetOutputMax;
      end else begin
         seed_constant_ff <= seed_constant_in;
         output_max_ff    <= output_max_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      seed_ff   <= seed_in;
      bound_ff  <= bound_in;
      draw_ff   <= draw_in;
      cutoff_ff <= cutoff_in;
      rsp_ff    <= rsp_in;
   end

   assign status.bound_zero = (bound_ff == '0);
   assign status.div_done   = div_done;
   assign status.draw_ok    = (draw_ff <= cutoff_ff);
   assign rsp_data          = rsp_ff;

endmodule

`default_nettype wire

### src/sfpbd_ctrl.sv
`default_nettype none

module sfpbd_ctrl
   import sfpbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [1:0]       req_func,
   output logic                  busy,
   output sfpbd_cmd_type         cmd,
   input  wire sfpbd_status_type status,
   output logic                  rsp_strobe
);

   sfpbd_state_type       state_ff, state_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      busy     = 1'b1;
      cmd      = '{capture: 1'b0, load: 1'b0, zero_seed: 1'b0, step: 1'b0,
                   div_start: 1'b0, div_src: DIV_OUTPUT_MAX, cutoff_load: 1'b0,
                   rsp_load: 1'b0, rsp_src: RSP_RAW};
      case (state_ff)
         ST_INIT: begin
            // After reset the words are seeded with zero.
            cmd.load      = 1'b1;
            cmd.zero_seed = 1'b1;
            cnt_in        = '0;
            state_in      = ST_WARM;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               case (req_func)
                  FuncSeed:    state_in = ST_SEED_LOAD;
                  FuncRaw:     state_in = ST_RAW_STEP;
                  FuncBounded: state_in = ST_BND_CHECK;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEED_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_WARM;
         end
         ST_WARM: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(WarmupSteps - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW_STEP: begin
            cmd.step     = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_src  = RSP_RAW;
            state_in     = ST_IDLE;
         end
         ST_BND_CHECK: begin
            cnt_in = '0;
            if (status.bound_zero) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_src  = RSP_ERROR;
               state_in     = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_OUTPUT_MAX;
               state_in      = ST_CUT_DIV;
            end
         end
         ST_CUT_DIV: begin
            if (status.div_done) begin
               cmd.cutoff_load = 1'b1;
               state_in        = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cmd.step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // The last allowed draw is reduced even when it is above the cutoff.
            if (status.draw_ok || cnt_ff == CountWidth'(MaxTries - 1)) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_DRAW;
               state_in      = ST_RED_DIV;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_DRAW;
            end
         end
         ST_RED_DIV: begin
            if (status.div_done) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_src  = RSP_REMAINDER;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two results in consecutive cycles");

   a_try_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && cnt_ff == CountWidth'(MaxTries - 1))
         |=> state_ff == ST_RED_DIV)
      else $error("bounded draw went past its try limit");
`endif

endmodule

`default_nettype wire

### src/small_fast_prng_bounded_draw.sv
`default_nettype none

// Small fast pseudo-random generator with raw and unbiased bounded draws.
// Request channel: an item (req_data) is taken at a clock edge with start
// high and busy low. Func seed loads the four state words and runs 20
// warm-up steps; func raw draw runs one step; func bounded draw returns a
// value below req_data.bound; the unused func code is dropped.
// Result channel: rsp_data is valid for exactly one cycle with rsp_strobe;
// the receiver cannot stall it, and nothing ever waits on it.
// Configuration channel: csr_ready is always high; csr_index selects
// the seed constant (0) or the output mask (1); other indexes are ignored.
// Sequence after acceptance: seed loads the words, runs the warm-up steps and
// gives no result; raw draw keeps busy for its single step, and the strobe
// follows in the next cycle; a bounded draw with bound zero answers likewise
// with error set. Otherwise a bounded draw checks the bound, then the serial
// remainder unit, one bit a cycle, runs once for the cutoff; each draw then
// takes a step and a check, until one is within the cutoff or the try limit
// is hit; the unit runs once more for the final reduction; the strobe follows
// in the next cycle. After reset the block seeds itself with zero while busy.
module small_fast_prng_bounded_draw
   import sfpbd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire sfpbd_req_type            req_data,
   output logic                          rsp_strobe,
   output sfpbd_rsp_type                 rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [WordWidth-1:0]     csr_data
);

   sfpbd_cmd_type    cmd;
   sfpbd_status_type status;

   assign csr_ready = 1'b1;

   sfpbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_data.func),
      .busy       (busy),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe)
   );

   sfpbd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
